### hdl/bse_pkg.sv
// bech32 string encoder package: item structs, command queue entry, fsm states
// polymod step and alphabet lookup; no dependencies
`timescale 1ns / 1ps
package bse_pkg;

  typedef struct packed {
    logic       mode;
    logic [7:0] value;
    logic       checksum_variant;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic [2:0] status;
    logic       end_of_string;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_CHAR  = 3'd1,
    ST_MIXED     = 3'd2,
    ST_LENGTH    = 3'd3,
    ST_RANGE     = 3'd4,
    ST_ORDER     = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CMD_PFX = 2'd0,
    CMD_DAT = 2'd1,
    CMD_ERR = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic       first;
    logic       last;
    logic       variant;
    logic [7:0] val;
    status_e    code;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE, S_PFX, S_SEP, S_REP, S_DAT, S_ZERO, S_CK, S_ERR
  } back_state_e;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam logic [29:0] BECH32_K  = 30'h1;
  localparam logic [29:0] BECH32M_K = 30'h2bc830a3;
  localparam logic [6:0]  SEP_CHAR  = 7'h31;
  localparam logic [255:0] ALPHABET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";
  localparam logic [29:0] GEN0 = 30'h3b6a57b2;
  localparam logic [29:0] GEN1 = 30'h26508e6d;
  localparam logic [29:0] GEN2 = 30'h1ea119fa;
  localparam logic [29:0] GEN3 = 30'h3d4233dd;
  localparam logic [29:0] GEN4 = 30'h2a1462b3;

  function automatic logic [29:0] mix(input logic [29:0] acc, input logic [4:0] v);
    logic [4:0]  top;
    logic [29:0] r;
    top = acc[29:25];
    r   = {acc[24:0], v};
    if (top[0]) r = r ^ GEN0;
    if (top[1]) r = r ^ GEN1;
    if (top[2]) r = r ^ GEN2;
    if (top[3]) r = r ^ GEN3;
    if (top[4]) r = r ^ GEN4;
    return r;
  endfunction

  function automatic logic [6:0] alpha(input logic [4:0] d);
    logic [7:0] base;
    base = {~d, 3'b000};
    return ALPHABET[base +: 7];
  endfunction

endpackage

### hdl/bse_front.sv
// front end: accepts input items, tracks prefix/case/order state, flags errors
// depends on bse_pkg; pushes commands into the queue
`timescale 1ns / 1ps
module bse_front import bse_pkg::*; #(
  parameter int unsigned PREFIX_MAX = 83
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_i,
  input  logic     q_full_i,
  output logic     q_push_o,
  output cmd_t     q_cmd_o
);
  localparam int unsigned CW = $clog2(PREFIX_MAX + 1);

  logic [CW-1:0] pcnt_q, pcnt_d;
  logic lower_q, lower_d, upper_q, upper_d, indata_q, indata_d;
  status_e err_q, err_d;
  status_e e;
  logic is_lo, is_up, acc;
  logic [7:0] lc;

  assign in_stall_o = q_full_i;
  assign acc = in_valid_i && !q_full_i;

  always_comb begin
    is_lo = (in_i.value >= 8'h61) && (in_i.value <= 8'h7a);
    is_up = (in_i.value >= 8'h41) && (in_i.value <= 8'h5a);
    lc    = is_up ? (in_i.value + 8'h20) : in_i.value;
    e     = ST_OK;
    pcnt_d = pcnt_q; lower_d = lower_q; upper_d = upper_q;
    indata_d = indata_q; err_d = err_q;
    q_push_o = 1'b0;
    q_cmd_o = '{kind: CMD_PFX, first: !indata_q, last: in_i.last,
                variant: in_i.checksum_variant, val: lc, code: ST_OK};
    if (err_q == ST_OK) begin
      if (!in_i.mode) begin
        if (indata_q) e = ST_ORDER;
        else if (pcnt_q >= CW'(PREFIX_MAX)) e = ST_LENGTH;
        else if (in_i.value < 8'd33 || in_i.value > 8'd126) e = ST_BAD_CHAR;
        else if ((lower_q || is_lo) && (upper_q || is_up)) e = ST_MIXED;
      end else begin
        if (!indata_q && pcnt_q == '0) e = ST_LENGTH;
        else if (in_i.value > 8'd31) e = ST_RANGE;
        q_cmd_o.kind = CMD_DAT;
        q_cmd_o.val  = in_i.value;
      end
    end else begin
      e = err_q;
    end
    if (acc) begin
      if (e != ST_OK) begin
        err_d = e;
        if (in_i.last) begin
          q_push_o = 1'b1;
          q_cmd_o.kind = CMD_ERR;
          q_cmd_o.code = e;
        end
      end else begin
        q_push_o = 1'b1;
        if (!in_i.mode) begin
          pcnt_d = pcnt_q + 1'b1;
          lower_d = lower_q || is_lo;
          upper_d = upper_q || is_up;
        end else begin
          indata_d = 1'b1;
        end
      end
      if (in_i.last) begin
        pcnt_d = '0; lower_d = 1'b0; upper_d = 1'b0;
        indata_d = 1'b0; err_d = ST_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcnt_q <= '0; lower_q <= 1'b0; upper_q <= 1'b0;
      indata_q <= 1'b0; err_q <= ST_OK;
    end else begin
      pcnt_q <= pcnt_d; lower_q <= lower_d; upper_q <= upper_d;
      indata_q <= indata_d; err_q <= err_d;
    end
  end
endmodule

### hdl/bse_fifo.sv
// small command queue between front and back
// depends on bse_pkg for the command type and the queue depth
`timescale 1ns / 1ps
module bse_fifo import bse_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t cmd_o
);
  localparam int unsigned PW = $clog2(FIFO_DEPTH);

  cmd_t mem_q [FIFO_DEPTH];
  logic [PW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [PW:0]   cnt_q, cnt_d;

  assign full_o  = cnt_q == (PW+1)'(FIFO_DEPTH);
  assign empty_o = cnt_q == '0;
  assign cmd_o   = mem_q[rp_q];

  always_comb begin
    wp_d = push_i ? wp_q + 1'b1 : wp_q;
    rp_d = pop_i ? rp_q + 1'b1 : rp_q;
    cnt_d = cnt_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      wp_q <= wp_d; rp_q <= rp_d; cnt_q <= cnt_d;
    end
  end
endmodule

### hdl/bse_back.sv
// back end: polymod sequencer, prefix low-part buffer and output register
// depends on bse_pkg; pops commands from the queue
`timescale 1ns / 1ps
module bse_back import bse_pkg::*; #(
  parameter int unsigned PREFIX_MAX = 83
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_empty_i,
  input  cmd_t      q_cmd_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_o
);
  localparam int unsigned CW = $clog2(PREFIX_MAX + 1);
  localparam int unsigned AW = (PREFIX_MAX > 1) ? $clog2(PREFIX_MAX) : 1;

  back_state_e state_q, state_d;
  cmd_t cur_q, cur_d;
  logic [29:0] acc_q, acc_d, pm_q, pm_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] rd_idx_q, rd_idx_d;
  logic [2:0] zc_q, zc_d;
  logic [4:0] mem_q [PREFIX_MAX];
  logic [4:0] rdata_q;
  logic mem_we, emit, out_free, out_valid_q;
  out_item_t emit_data, out_q;

  assign out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_o = out_q;
  assign q_pop_o = (state_q == S_IDLE) && !q_empty_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (!q_empty_i) begin
        case (q_cmd_i.kind)
          CMD_PFX: state_d = S_PFX;
          CMD_DAT: state_d = q_cmd_i.first ? S_SEP : S_DAT;
          default: state_d = S_ERR;
        endcase
      end
      S_PFX:  if (out_free) state_d = cur_q.last ? S_SEP : S_IDLE;
      S_SEP:  if (out_free) state_d = S_REP;
      S_REP:  if (CW'(rd_idx_q) + 1'b1 == cnt_q)
                state_d = (cur_q.kind == CMD_DAT) ? S_DAT : S_ZERO;
      S_DAT:  if (out_free) state_d = cur_q.last ? S_ZERO : S_IDLE;
      S_ZERO: if (zc_q == 3'd5) state_d = S_CK;
      S_CK:   if (out_free && zc_q == 3'd5) state_d = S_IDLE;
      S_ERR:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cur_d = q_pop_o ? q_cmd_i : cur_q;
    acc_d = acc_q; pm_d = pm_q; cnt_d = cnt_q;
    rd_idx_d = rd_idx_q; zc_d = zc_q;
    mem_we = 1'b0; emit = 1'b0;
    emit_data = '{out_char: cur_q.val[6:0], status: ST_OK, end_of_string: 1'b0};
    case (state_q)
      S_PFX: if (out_free) begin
        emit = 1'b1; mem_we = 1'b1;
        acc_d = mix(acc_q, {2'b00, cur_q.val[7:5]});
        cnt_d = cnt_q + 1'b1;
      end
      S_SEP: if (out_free) begin
        emit = 1'b1; emit_data.out_char = SEP_CHAR;
        acc_d = mix(acc_q, 5'd0);
        rd_idx_d = '0;
      end
      S_REP: begin
        acc_d = mix(acc_q, rdata_q);
        rd_idx_d = rd_idx_q + 1'b1;
        zc_d = '0;
      end
      S_DAT: if (out_free) begin
        emit = 1'b1; emit_data.out_char = alpha(cur_q.val[4:0]);
        acc_d = mix(acc_q, cur_q.val[4:0]);
        zc_d = '0;
      end
      S_ZERO: begin
        acc_d = mix(acc_q, 5'd0);
        zc_d = zc_q + 1'b1;
        if (zc_q == 3'd5) begin
          pm_d = acc_d ^ (cur_q.variant ? BECH32M_K : BECH32_K);
          zc_d = '0;
        end
      end
      S_CK: if (out_free) begin
        emit = 1'b1; emit_data.out_char = alpha(pm_q[29:25]);
        emit_data.end_of_string = zc_q == 3'd5;
        pm_d = {pm_q[24:0], 5'd0};
        zc_d = zc_q + 1'b1;
        if (zc_q == 3'd5) begin
          acc_d = 30'd1; cnt_d = '0;
        end
      end
      S_ERR: if (out_free) begin
        emit = 1'b1;
        emit_data = '{out_char: 7'd0, status: cur_q.code, end_of_string: 1'b1};
        acc_d = 30'd1; cnt_d = '0;
      end
      default: ;
    endcase
  end

  // prefix low parts, registered read one index ahead
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[cnt_q[AW-1:0]] <= cur_q.val[4:0];
    rdata_q <= mem_q[rd_idx_d];
    if (emit) out_q <= emit_data;
    cur_q <= cur_d;
    pm_q <= pm_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; acc_q <= 30'd1; cnt_q <= '0;
      rd_idx_q <= '0; zc_q <= '0; out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d; acc_q <= acc_d; cnt_q <= cnt_d;
      rd_idx_q <= rd_idx_d; zc_q <= zc_d;
      if (emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end
endmodule

### hdl/bech32_string_encoder.sv
// channel   dir  payload     handshake
// in        in   in_item_t   in_valid_i / in_stall_o
// out       out  out_item_t  out_valid_o / out_stall_i
// prefix character: the back sequencer pops it, then echoes it; data value: pop, then character
// first data item: pop, separator, replay of the prefix buffer, then the character
// last item: further polymod steps over zeros, then 6 checksum characters
// queue of four commands lets the front accept while the back works
// reset is asynchronous, active low; output stalls hold the emitting states of the back sequencer
// top level: front, command queue, back; depends on bse_pkg
`timescale 1ns / 1ps
module bech32_string_encoder import bse_pkg::*; #(
  parameter int unsigned PREFIX_MAX = 83
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_o
);
  logic push, pop, full, empty;
  cmd_t cmd_in, cmd_out;

  bse_front #(.PREFIX_MAX(PREFIX_MAX)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_i,
    .q_full_i(full), .q_push_o(push), .q_cmd_o(cmd_in)
  );

  bse_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .cmd_i(cmd_in), .full_o(full),
    .pop_i(pop), .empty_o(empty), .cmd_o(cmd_out)
  );

  bse_back #(.PREFIX_MAX(PREFIX_MAX)) u_back (
    .clk_i, .rst_ni, .q_empty_i(empty), .q_cmd_i(cmd_out), .q_pop_o(pop),
    .out_valid_o, .out_stall_i, .out_o
  );
endmodule

### hdl/bse_checker.sv
// port-level checks on the encoder output channel
// depends on bse_pkg; bound to bech32_string_encoder
`timescale 1ns / 1ps
module bse_checker import bse_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_o
);
  // a stalled item stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("stalled output changed");

  // error items carry no character and close the string
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status != ST_OK |-> out_o.out_char == 7'd0 && out_o.end_of_string)
    else $error("malformed error item");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_o.status <= ST_ORDER)
    else $error("status out of range");

  // ok items are printable characters
  a_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status == ST_OK |-> out_o.out_char >= 7'd33 && out_o.out_char <= 7'd126)
    else $error("non-printable character");
endmodule

bind bech32_string_encoder bse_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i), .out_o(out_o)
);

### tb/bech32_string_encoder_checker.sv
// bech32 string encoder checker: predicts results of accepted items and compares
// them with accepted results; depends on bse_pkg
`timescale 1ns / 1ps
module bech32_string_encoder_checker import bse_pkg::*; #(
  parameter int unsigned PREFIX_MAX = 83
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_i,
  output int        fail_count_o,
  output int        pending_o
);

  localparam string CHARSET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

  logic [4:0]  low_parts [PREFIX_MAX];
  int          pfx_len;
  logic [29:0] poly;
  bit          seen_lower, seen_upper, in_data;
  status_e     err;
  out_item_t   expected_chars [$];

  function automatic logic [29:0] poly_step(input logic [29:0] acc, input logic [4:0] v);
    logic [29:0] r;
    r = {acc[24:0], v};
    if (acc[25]) r ^= 30'h3b6a57b2;
    if (acc[26]) r ^= 30'h26508e6d;
    if (acc[27]) r ^= 30'h1ea119fa;
    if (acc[28]) r ^= 30'h3d4233dd;
    if (acc[29]) r ^= 30'h2a1462b3;
    return r;
  endfunction

  function automatic logic [6:0] charset_char(input logic [4:0] d);
    return 7'(CHARSET[d]);
  endfunction

  task automatic clear_string();
    pfx_len = 0;
    poly = 30'd1;
    seen_lower = 0;
    seen_upper = 0;
    in_data = 0;
    err = ST_OK;
  endtask

  task automatic start_data(ref out_item_t res [$]);
    poly = poly_step(poly, 5'd0);
    for (int i = 0; i < pfx_len; i++) poly = poly_step(poly, low_parts[i]);
    in_data = 1;
    res.push_back('{7'h31, ST_OK, 1'b0});
  endtask

  task automatic predict_item(input in_item_t it);
    out_item_t   res [$];
    logic [7:0]  lc;
    logic [29:0] pm;
    lc = it.value;
    if (err == ST_OK) begin
      if (it.mode == 1'b0) begin
        if (in_data) err = ST_ORDER;
        else if (pfx_len >= PREFIX_MAX) err = ST_LENGTH;
        else if (it.value < 33 || it.value > 126) err = ST_BAD_CHAR;
        else begin
          if (it.value >= "a" && it.value <= "z") seen_lower = 1;
          if (it.value >= "A" && it.value <= "Z") begin
            seen_upper = 1;
            lc = it.value + 8'd32;
          end
          if (seen_lower && seen_upper) err = ST_MIXED;
          else begin
            poly = poly_step(poly, 5'(lc >> 5));
            low_parts[pfx_len] = lc[4:0];
            pfx_len++;
            res.push_back('{lc[6:0], ST_OK, 1'b0});
          end
        end
      end else begin
        if (!in_data) begin
          if (pfx_len == 0) err = ST_LENGTH;
          else start_data(res);
        end
        if (err == ST_OK) begin
          if (it.value > 31) err = ST_RANGE;
          else begin
            poly = poly_step(poly, it.value[4:0]);
            res.push_back('{charset_char(it.value[4:0]), ST_OK, 1'b0});
          end
        end
      end
      if (err == ST_OK && it.last) begin
        if (!in_data) start_data(res);
        for (int i = 0; i < 6; i++) poly = poly_step(poly, 5'd0);
        pm = poly ^ (it.checksum_variant ? 30'h2bc830a3 : 30'h1);
        for (int i = 0; i < 6; i++)
          res.push_back('{charset_char(pm[5*(5-i) +: 5]), ST_OK, 1'(i == 5)});
      end
    end
    if (err != ST_OK) begin
      res.delete();
      if (it.last) res.push_back('{7'd0, err, 1'b1});
    end
    if (it.last) clear_string();
    foreach (res[i]) expected_chars.push_back(res[i]);
  endtask

  initial begin
    fail_count_o = 0;
    clear_string();
  end

  assign pending_o = expected_chars.size();

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) predict_item(in_i);
      if (out_valid_i && !out_stall_i) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected result char=%h status=%0d end=%b", $time,
                   out_i.out_char, out_i.status, out_i.end_of_string);
          fail_count_o++;
        end else begin
          want = expected_chars.pop_front();
          if (want.out_char !== out_i.out_char)
            $display("%0t: out_char expected %h actual %h", $time, want.out_char,
                     out_i.out_char);
          if (want.status !== out_i.status)
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     out_i.status);
          if (want.end_of_string !== out_i.end_of_string)
            $display("%0t: end_of_string expected %b actual %b", $time,
                     want.end_of_string, out_i.end_of_string);
          if (want !== out_i) fail_count_o++;
        end
      end
    end
  end

endmodule

### tb/bech32_string_encoder_tb.sv
// bech32 string encoder testbench top: clock, reset, string stimulus, output stalls
// depends on bse_pkg, bech32_string_encoder and bech32_string_encoder_checker
`timescale 1ns / 1ps
module bech32_string_encoder_tb;
  import bse_pkg::*;

  typedef enum int {
    K_GOOD, K_BAD_CHAR, K_MIXED, K_LENGTH, K_RANGE, K_ORDER, K_EMPTY
  } string_kind_e;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_o;
  int        fail_count;
  int        pending;
  int        items_sent;
  int        idle_pct;
  int        stall_pct;
  bit        hold_req;

  bech32_string_encoder dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_i, .out_valid_o, .out_stall_i, .out_o
  );

  bech32_string_encoder_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_i, .out_valid_i(out_valid_o),
    .out_stall_i, .out_i(out_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("bech32_string_encoder regression: fail");
    $finish;
  end

  // receiver: random stalls, or one long hold-off while the sender keeps going
  initial begin
    out_stall_i = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1;
        repeat (300) @(posedge clk_i);
        hold_req = 0;
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_queue(input in_item_t q [$]);
    foreach (q[i]) begin
      in_valid_i <= 1;
      in_i <= q[i];
      do @(posedge clk_i); while (in_stall_o);
      items_sent++;
      if ($urandom_range(99) < idle_pct) begin
        in_valid_i <= 0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end
    end
    in_valid_i <= 0;
  endtask

  function automatic in_item_t mk(input bit m, input logic [7:0] v);
    return '{m, v, 1'($urandom_range(1)), 1'b0};
  endfunction

  function automatic logic [7:0] pfx_char(input bit up);
    logic [7:0] c;
    c = 8'($urandom_range(33, 126));
    if (up && c >= "a" && c <= "z") c -= 8'd32;
    if (!up && c >= "A" && c <= "Z") c += 8'd32;
    return c;
  endfunction

  task automatic send_string(input string_kind_e kind, input int plen, input int dlen);
    in_item_t q [$];
    bit       up;
    int       pos;
    up = $urandom_range(1);
    if (kind == K_EMPTY) plen = 0;
    if (kind == K_LENGTH) plen = 84 + $urandom_range(2);
    if (kind == K_MIXED && plen < 2) plen = 2;
    if (kind inside {K_EMPTY, K_RANGE, K_ORDER} && dlen < 1) dlen = 1;
    for (int i = 0; i < plen; i++) q.push_back(mk(0, pfx_char(up)));
    for (int i = 0; i < dlen; i++) q.push_back(mk(1, 8'($urandom_range(31))));
    case (kind)
      K_BAD_CHAR: begin
        pos = $urandom_range(plen - 1);
        q[pos].value = $urandom_range(1) ? 8'($urandom_range(32)) :
                       8'($urandom_range(127, 255));
      end
      K_MIXED: begin
        q[0].value = up ? "Q" : "q";
        q[plen - 1].value = up ? 8'($urandom_range("a", "z")) : 8'($urandom_range("A", "Z"));
      end
      K_RANGE: q[plen + $urandom_range(dlen - 1)].value = 8'($urandom_range(32, 255));
      K_ORDER: q.push_back(mk(0, pfx_char(up)));
      default: ;
    endcase
    // trailing noise after an error is swallowed, then the last item gives the code
    if (kind != K_GOOD) repeat ($urandom_range(2)) q.push_back(mk(1, 8'($urandom)));
    q[$].last = 1;
    send_queue(q);
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (pending != 0);
    repeat (100) @(posedge clk_i);
  endtask

  initial begin
    in_item_t     q [$];
    string_kind_e kind;
    int           phase;
    rst_ni = 0;
    in_valid_i = 0;
    in_i = '0;
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 0;
    items_sent = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: prefix only, extremes of data, each error
    q = '{'{1'b0, "a", 1'b0, 1'b1}};
    send_queue(q);
    q = '{'{1'b0, "A", 1'b0, 1'b0}, '{1'b1, 8'd0, 1'b0, 1'b0}, '{1'b1, 8'd31, 1'b1, 1'b1}};
    send_queue(q);
    q = '{'{1'b0, 8'd33, 1'b0, 1'b0}, '{1'b0, 8'd126, 1'b1, 1'b1}};
    send_queue(q);
    q = '{'{1'b0, 8'd32, 1'b0, 1'b1}};
    send_queue(q);
    q = '{'{1'b0, 8'd255, 1'b0, 1'b1}};
    send_queue(q);
    q = '{'{1'b0, "x", 1'b0, 1'b0}, '{1'b0, "Y", 1'b0, 1'b1}};
    send_queue(q);
    q = '{'{1'b1, 8'd3, 1'b0, 1'b1}};
    send_queue(q);
    q = '{'{1'b0, "b", 1'b0, 1'b0}, '{1'b1, 8'd255, 1'b0, 1'b1}};
    send_queue(q);
    q = '{'{1'b0, "b", 1'b0, 1'b0}, '{1'b1, 8'd5, 1'b0, 1'b0}, '{1'b0, "c", 1'b1, 1'b1}};
    send_queue(q);
    send_string(K_GOOD, 83, 2);
    wait_drained();

    phase = 0;
    while (items_sent < 400) begin
      if (items_sent >= 80 * (phase + 1) && phase < 4) begin
        phase++;
        case (phase)
          1: begin idle_pct = 66; stall_pct = 0;  end
          2: begin idle_pct = 0;  stall_pct = 66; end
          3: begin idle_pct = 31; stall_pct = 31; end
          default: begin idle_pct = 0; stall_pct = 0; hold_req = 1; end
        endcase
      end
      if ($urandom_range(99) < 75) kind = K_GOOD;
      else kind = string_kind_e'($urandom_range(K_BAD_CHAR, K_EMPTY));
      if (kind == K_LENGTH && $urandom_range(3) != 0) kind = K_RANGE;
      send_string(kind, $urandom_range(99) < 3 ? 83 : $urandom_range(1, 6),
                  $urandom_range(0, 10));
      if ($urandom_range(99) < 5) wait_drained();
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("bech32_string_encoder regression: pass");
    end else begin
      $display("bech32_string_encoder regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
hdl/bse_pkg.sv
hdl/bse_front.sv
hdl/bse_fifo.sv
hdl/bse_back.sv
hdl/bech32_string_encoder.sv
hdl/bse_checker.sv
tb/bech32_string_encoder_checker.sv
tb/bech32_string_encoder_tb.sv
